[rtl/tossf_pkg.sv]
// shared types, constants and arithmetic helpers for the state-space filter core
package tossf_pkg;

   // filter dimensions and number formats
   localparam int STATE_ORDER = 3;
   localparam int FRAC_BITS   = 12;
   localparam int COEF_W      = 16;
   localparam int DATA_W      = 32;
   localparam int PACK_W      = STATE_ORDER * COEF_W;
   localparam int PROD_W      = DATA_W + COEF_W;
   localparam int ACC_W       = PROD_W + 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = PACK_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_A_ROW_ZERO    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_A_ROW_ONE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_A_ROW_TWO     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_B_VECTOR      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_C_VECTOR      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_D_GAIN        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_STATE = 3'd6;

   // item kinds
   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_LOAD   = 1'b1
   } kind_type;

   // saturation bounds in accumulator width
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

   // pick one signed coefficient out of a packed register
   function automatic logic signed [COEF_W-1:0] coef_of(
      input logic [PACK_W-1:0] packed_value,
      input int                idx
   );
      coef_of = signed'(packed_value[idx*COEF_W +: COEF_W]);
   endfunction

   // floor shift by the fraction width, then clamp to the data width
   function automatic logic signed [DATA_W-1:0] shift_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] shifted;
      shifted = acc >>> FRAC_BITS;
      if (shifted > SAT_HI) begin
         shift_sat = SAT_HI[DATA_W-1:0];
      end else if (shifted < SAT_LO) begin
         shift_sat = SAT_LO[DATA_W-1:0];
      end else begin
         shift_sat = shifted[DATA_W-1:0];
      end
   endfunction

endpackage

[rtl/third_order_state_space_filter_core.sv]
// third-order fixed-point state-space filter core, top level
// a sample transfer shows its result in the output register in the cycle after the transfer
// throughput: one item per cycle; the state update is one pass of twelve parallel
//    products per edge, and intake stalls only while a result waits unaccepted
// a load item copies the initial state and gives no result
// synchronous reset clears state, previous input, registers and output register
module third_order_state_space_filter_core (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic                                        req_kind,
   input  logic signed [tossf_pkg::COEF_W-1:0]         req_sample,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [tossf_pkg::DATA_W-1:0]         rsp_output_value,
   input  logic                                        csr_write_enable,
   input  logic [tossf_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [tossf_pkg::CSR_DATA_W-1:0]            csr_write_data
);

   localparam int N = tossf_pkg::STATE_ORDER;

   // configuration registers
   logic [tossf_pkg::PACK_W-1:0]        a_row_ff [N];
   logic [tossf_pkg::PACK_W-1:0]        b_vec_ff;
   logic [tossf_pkg::PACK_W-1:0]        c_vec_ff;
   logic signed [tossf_pkg::COEF_W-1:0] d_gain_ff;
   logic [tossf_pkg::PACK_W-1:0]        init_ff;

   // filter state
   logic signed [tossf_pkg::DATA_W-1:0] state_ff [N];
   logic signed [tossf_pkg::DATA_W-1:0] state_in [N];
   logic signed [tossf_pkg::COEF_W-1:0] last_sample_ff;
   logic signed [tossf_pkg::COEF_W-1:0] last_sample_in;

   // result register
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [tossf_pkg::DATA_W-1:0] rsp_value_ff;
   logic signed [tossf_pkg::DATA_W-1:0] rsp_value_in;

   logic                                in_xfer;
   logic                                is_load;
   logic signed [tossf_pkg::DATA_W-1:0] y_value;
   logic signed [tossf_pkg::DATA_W-1:0] next_state [N];

   assign req_ready        = !rsp_valid_ff || rsp_ready;
   assign in_xfer          = req_valid && req_ready;
   assign is_load          = (tossf_pkg::kind_type'(req_kind) == tossf_pkg::KIND_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_value = rsp_value_ff;

   // output from the old state and the previous input
   always_comb begin
      logic signed [tossf_pkg::PROD_W-1:0] prod;
      logic signed [tossf_pkg::ACC_W-1:0]  acc;
      prod = last_sample_ff * d_gain_ff;
      acc  = tossf_pkg::ACC_W'(prod);
      for (int j = 0; j < N; j++) begin
         prod = state_ff[j] * tossf_pkg::coef_of(c_vec_ff, j);
         acc  = acc + tossf_pkg::ACC_W'(prod);
      end
      y_value = tossf_pkg::shift_sat(acc);
   end

   // state advance, every row from the old state
   always_comb begin
      logic signed [tossf_pkg::PROD_W-1:0] prod;
      logic signed [tossf_pkg::ACC_W-1:0]  acc;
      for (int i = 0; i < N; i++) begin
         prod = req_sample * tossf_pkg::coef_of(b_vec_ff, i);
         acc  = tossf_pkg::ACC_W'(prod);
         for (int j = 0; j < N; j++) begin
            prod = state_ff[j] * tossf_pkg::coef_of(a_row_ff[i], j);
            acc  = acc + tossf_pkg::ACC_W'(prod);
         end
         next_state[i] = tossf_pkg::shift_sat(acc);
      end
   end

   // next state and previous input on a transfer
   always_comb begin
      last_sample_in = last_sample_ff;
      for (int i = 0; i < N; i++) begin
         state_in[i] = state_ff[i];
      end
      if (in_xfer) begin
         if (is_load) begin
            last_sample_in = '0;
            for (int i = 0; i < N; i++) begin
               state_in[i] = tossf_pkg::DATA_W'(tossf_pkg::coef_of(init_ff, i));
            end
         end else begin
            last_sample_in = req_sample;
            for (int i = 0; i < N; i++) begin
               state_in[i] = next_state[i];
            end
         end
      end
   end

   // result register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (in_xfer && !is_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = y_value;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_value_ff   <= '0;
         last_sample_ff <= '0;
         for (int i = 0; i < N; i++) begin
            state_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         rsp_value_ff   <= rsp_value_in;
         last_sample_ff <= last_sample_in;
         for (int i = 0; i < N; i++) begin
            state_ff[i] <= state_in[i];
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            a_row_ff[i] <= '0;
         end
         b_vec_ff  <= '0;
         c_vec_ff  <= '0;
         d_gain_ff <= '0;
         init_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tossf_pkg::REG_A_ROW_ZERO:    a_row_ff[0] <= csr_write_data;
            tossf_pkg::REG_A_ROW_ONE:     a_row_ff[1] <= csr_write_data;
            tossf_pkg::REG_A_ROW_TWO:     a_row_ff[2] <= csr_write_data;
            tossf_pkg::REG_B_VECTOR:      b_vec_ff    <= csr_write_data;
            tossf_pkg::REG_C_VECTOR:      c_vec_ff    <= csr_write_data;
            tossf_pkg::REG_D_GAIN:        d_gain_ff   <= csr_write_data[tossf_pkg::COEF_W-1:0];
            tossf_pkg::REG_INITIAL_STATE: init_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // a sample transfer always fills the result register
   assert property (@(posedge clock) disable iff (reset)
      (in_xfer && !is_load) |=> rsp_valid_ff)
      else $error("sample transfer did not produce a result");

   // a load transfer leaves the result register alone unless the receiver takes a result
   assert property (@(posedge clock) disable iff (reset)
      (in_xfer && is_load && !rsp_ready) |=> $stable(rsp_valid_ff) && $stable(rsp_value_ff))
      else $error("load transfer disturbed a pending result");

   // a load clears the previous input and seeds state element zero
   assert property (@(posedge clock) disable iff (reset)
      (in_xfer && is_load) |=> (last_sample_ff == '0) &&
         (state_ff[0] == tossf_pkg::DATA_W'($past(tossf_pkg::coef_of(init_ff, 0)))))
      else $error("load did not apply the initial state");

   // without a transfer the state holds
   assert property (@(posedge clock) disable iff (reset)
      !in_xfer |=> $stable(state_ff[0]) && $stable(state_ff[1]) && $stable(state_ff[2]) &&
         $stable(last_sample_ff))
      else $error("state changed without a transfer");

   // intake only stalls behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("input stalled with no pending result");

endmodule

[test/tb.sv]
// testbench for the third-order state-space filter core: predicted outputs checked per transfer
module tb;

   // run limits and helper codes
   localparam int RUN_LIMIT    = 200000;
   localparam int SETTLE_EDGES = 4;
   localparam int REPORT_LINES = 40;
   localparam logic [tossf_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam longint OUT_MAX = 64'sd2147483647;
   localparam longint OUT_MIN = -64'sd2147483648;

   typedef enum int {
      COEF_SMALL,
      COEF_ANY,
      COEF_EXTREME
   } coef_style_type;

   // block ports
   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_kind;
   logic signed [tossf_pkg::COEF_W-1:0]  req_sample;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [tossf_pkg::DATA_W-1:0]  rsp_output_value;
   logic                                 csr_write_enable;
   logic [tossf_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [tossf_pkg::CSR_DATA_W-1:0]     csr_write_data;

   // predicted filter state and register copy
   logic [tossf_pkg::PACK_W-1:0]         model_regs [7];
   logic signed [tossf_pkg::DATA_W-1:0]  model_x [tossf_pkg::STATE_ORDER];
   logic signed [tossf_pkg::COEF_W-1:0]  model_u_prev;
   logic signed [tossf_pkg::DATA_W-1:0]  expected_outputs [$];

   // bookkeeping
   int   error_count;
   int   results_checked;
   int   samples_sent;
   int   loads_sent;
   int   csr_writes;
   int   input_stall_cycles;
   int   cycle_count;
   logic signed [tossf_pkg::DATA_W-1:0] want;

   // idling controls
   bit   sender_idles;
   bit   receiver_idles;
   int   hold_requests;
   int   hold_served;
   int   hold_cycles;
   int   stall_left;
   int   roll;

   third_order_state_space_filter_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_output_value (rsp_output_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // signed element of a packed coefficient word
   function automatic longint coef_at(input logic [tossf_pkg::PACK_W-1:0] word, input int idx);
      logic signed [tossf_pkg::COEF_W-1:0] c;
      c = word[idx*tossf_pkg::COEF_W +: tossf_pkg::COEF_W];
      return longint'(c);
   endfunction

   // floor shift by the fraction width and clamp to the output width
   function automatic logic signed [tossf_pkg::DATA_W-1:0] floor_clamp(input longint acc);
      longint q;
      q = acc >>> tossf_pkg::FRAC_BITS;
      if (q > OUT_MAX) begin
         q = OUT_MAX;
      end else if (q < OUT_MIN) begin
         q = OUT_MIN;
      end
      return q[tossf_pkg::DATA_W-1:0];
   endfunction

   // append one predicted output
   task automatic queue_expected(input logic signed [tossf_pkg::DATA_W-1:0] v);
      expected_outputs = {expected_outputs, v};
   endtask

   // advance the predicted filter by one accepted item
   task automatic model_step(input tossf_pkg::kind_type kind_v,
                             input logic signed [tossf_pkg::COEF_W-1:0] u);
      longint acc;
      logic signed [tossf_pkg::DATA_W-1:0] next_x [tossf_pkg::STATE_ORDER];
      if (kind_v == tossf_pkg::KIND_LOAD) begin
         for (int i = 0; i < tossf_pkg::STATE_ORDER; i++) begin
            model_x[i] = tossf_pkg::DATA_W'(coef_at(model_regs[tossf_pkg::REG_INITIAL_STATE], i));
         end
         model_u_prev = '0;
      end else begin
         // output from the old state and the previous input
         acc = longint'(model_u_prev) * coef_at(model_regs[tossf_pkg::REG_D_GAIN], 0);
         for (int i = 0; i < tossf_pkg::STATE_ORDER; i++) begin
            acc += longint'(model_x[i]) * coef_at(model_regs[tossf_pkg::REG_C_VECTOR], i);
         end
         queue_expected(floor_clamp(acc));
         // every row uses the old state
         for (int i = 0; i < tossf_pkg::STATE_ORDER; i++) begin
            acc = longint'(u) * coef_at(model_regs[tossf_pkg::REG_B_VECTOR], i);
            for (int j = 0; j < tossf_pkg::STATE_ORDER; j++) begin
               acc += longint'(model_x[j]) *
                      coef_at(model_regs[int'(tossf_pkg::REG_A_ROW_ZERO) + i], j);
            end
            next_x[i] = floor_clamp(acc);
         end
         for (int i = 0; i < tossf_pkg::STATE_ORDER; i++) begin
            model_x[i] = next_x[i];
         end
         model_u_prev = u;
      end
   endtask

   // one mismatch, counted, with its line printed up to the report limit
   task automatic report_mismatch(input string what,
                                  input logic signed [tossf_pkg::DATA_W-1:0] exp_v,
                                  input logic signed [tossf_pkg::DATA_W-1:0] got_v);
      error_count++;
      if (error_count <= REPORT_LINES) begin
         $display("mismatch (%s) at result %0d: expected %0d, got %0d",
                  what, results_checked, exp_v, got_v);
      end
   endtask

   // register write, mirrored into the predictor
   task automatic write_register(input logic [tossf_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [tossf_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == tossf_pkg::REG_D_GAIN) begin
         model_regs[idx] = {{(tossf_pkg::PACK_W-tossf_pkg::COEF_W){1'b0}},
                            data[tossf_pkg::COEF_W-1:0]};
      end else if (idx <= tossf_pkg::REG_INITIAL_STATE) begin
         model_regs[idx] = data;
      end
      csr_writes++;
   endtask

   // sender gap: none unless the sender idles, then mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!sender_idles || r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // offer one item and hold it until the transfer
   task automatic send_item(input tossf_pkg::kind_type kind_v,
                            input logic signed [tossf_pkg::COEF_W-1:0] sample_v,
                            input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind_v;
      req_sample <= sample_v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_step(kind_v, sample_v);
      if (kind_v == tossf_pkg::KIND_LOAD) begin
         loads_sent++;
      end else begin
         samples_sent++;
      end
   endtask

   // stop offering, let every expected output arrive, then let a load settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_EDGES) @(posedge clock);
   endtask

   // one 16-bit coefficient of the given style
   function automatic logic [tossf_pkg::COEF_W-1:0] pick_coef(input coef_style_type style);
      int v;
      case (style)
         COEF_SMALL: begin
            v = int'($urandom_range(0, 4095)) - 2048;
         end
         COEF_EXTREME: begin
            case ($urandom_range(0, 4))
               0: v = 32767;
               1: v = -32768;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 65535));
         end
      endcase
      return v[tossf_pkg::COEF_W-1:0];
   endfunction

   function automatic logic [tossf_pkg::PACK_W-1:0] pick_word(input coef_style_type style);
      return {pick_coef(style), pick_coef(style), pick_coef(style)};
   endfunction

   // sample values: some fixed (both extremes, zero, minus one), the rest anywhere
   function automatic logic signed [tossf_pkg::COEF_W-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return tossf_pkg::COEF_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic tossf_pkg::kind_type pick_kind();
      return ($urandom_range(0, 99) < 8) ? tossf_pkg::KIND_LOAD : tossf_pkg::KIND_SAMPLE;
   endfunction

   // registers at reset, then the one-sample delay on the feedthrough term
   task automatic test_reset_values();
      send_item(tossf_pkg::KIND_SAMPLE, 16'sh7fff, 0);
      wait_idle();
      write_register(tossf_pkg::REG_C_VECTOR, {3{16'h1000}});
      write_register(tossf_pkg::REG_B_VECTOR, {16'hf000, 16'h0800, 16'h1000});
      // high bits beyond the gain width are dropped
      write_register(tossf_pkg::REG_D_GAIN, 48'ha5a5_c3c3_1000);
      send_item(tossf_pkg::KIND_SAMPLE, 16'sh1000, 0);
      send_item(tossf_pkg::KIND_SAMPLE, -16'sh1000, 0);
      send_item(tossf_pkg::KIND_SAMPLE, 16'sh0000, 1);
   endtask

   // largest coefficients and samples, saturating both ways
   task automatic test_saturation();
      wait_idle();
      write_register(tossf_pkg::REG_A_ROW_ZERO, {3{16'h7fff}});
      write_register(tossf_pkg::REG_A_ROW_ONE, {3{16'h7fff}});
      write_register(tossf_pkg::REG_A_ROW_TWO, {3{16'h7fff}});
      write_register(tossf_pkg::REG_B_VECTOR, {3{16'h7fff}});
      write_register(tossf_pkg::REG_C_VECTOR, {3{16'h7fff}});
      write_register(tossf_pkg::REG_D_GAIN, 48'h0000_0000_7fff);
      repeat (5) send_item(tossf_pkg::KIND_SAMPLE, 16'sh7fff, 0);
      wait_idle();
      write_register(tossf_pkg::REG_B_VECTOR, {3{16'h8000}});
      write_register(tossf_pkg::REG_C_VECTOR, {3{16'h8000}});
      write_register(tossf_pkg::REG_D_GAIN, 48'hffff_ffff_8000);
      write_register(tossf_pkg::REG_INITIAL_STATE, {16'h8000, 16'hffff, 16'h7fff});
      // index past the register list is ignored
      write_register(REG_UNUSED, 48'hffff_ffff_ffff);
      send_item(tossf_pkg::KIND_LOAD, 16'sh7fff, 0);
      send_item(tossf_pkg::KIND_SAMPLE, 16'sh8000, 0);
      repeat (3) send_item(tossf_pkg::KIND_SAMPLE, 16'sh7fff, 0);
      send_item(tossf_pkg::KIND_SAMPLE, 16'sh0000, 0);
   endtask

   // load items: sample field ignored, previous input cleared, no output
   task automatic test_load_items();
      wait_idle();
      write_register(tossf_pkg::REG_A_ROW_ZERO, pick_word(COEF_SMALL));
      write_register(tossf_pkg::REG_A_ROW_ONE, pick_word(COEF_SMALL));
      write_register(tossf_pkg::REG_A_ROW_TWO, pick_word(COEF_SMALL));
      write_register(tossf_pkg::REG_C_VECTOR, pick_word(COEF_SMALL));
      write_register(tossf_pkg::REG_INITIAL_STATE, pick_word(COEF_ANY));
      send_item(tossf_pkg::KIND_SAMPLE, pick_sample(), 0);
      send_item(tossf_pkg::KIND_LOAD, pick_sample(), 0);
      send_item(tossf_pkg::KIND_LOAD, pick_sample(), 0);
      send_item(tossf_pkg::KIND_SAMPLE, pick_sample(), 0);
      send_item(tossf_pkg::KIND_LOAD, pick_sample(), 2);
      send_item(tossf_pkg::KIND_SAMPLE, pick_sample(), 0);
      send_item(tossf_pkg::KIND_SAMPLE, pick_sample(), 0);
   endtask

   // one register setting followed by a stream of random items
   task automatic run_phase(input coef_style_type style, input int items, input bit idles);
      wait_idle();
      for (int r = 0; r <= int'(tossf_pkg::REG_INITIAL_STATE); r++) begin
         write_register(r[tossf_pkg::CSR_INDEX_W-1:0], pick_word(style));
      end
      if ($urandom_range(0, 1) == 1) begin
         write_register(REG_UNUSED, pick_word(COEF_ANY));
      end
      sender_idles   = idles;
      receiver_idles = idles;
      if ($urandom_range(0, 1) == 1) begin
         send_item(tossf_pkg::KIND_LOAD, pick_sample(), 0);
      end
      for (int n = 0; n < items; n++) begin
         send_item(pick_kind(), pick_sample(), pick_gap());
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   task automatic test_random_phases();
      run_phase(COEF_SMALL, 95, 1'b1);
      run_phase(COEF_ANY, 95, 1'b1);
      run_phase(COEF_EXTREME, 95, 1'b0);
      run_phase(COEF_SMALL, 95, 1'b1);
      run_phase(COEF_ANY, 95, 1'b1);
   endtask

   // receiver holds off for a long stretch while items keep coming back to back
   task automatic test_output_hold();
      wait_idle();
      sender_idles  = 1'b0;
      hold_cycles   = 300;
      hold_requests = hold_requests + 1;
      for (int n = 0; n < 60; n++) begin
         send_item(pick_kind(), pick_sample(), 0);
      end
      sender_idles = 1'b1;
   endtask

   // result receiver with random stalls while it idles, and the requested long hold
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         stall_left  = hold_cycles;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!receiver_idles) begin
         rsp_ready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = (roll < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            rsp_ready <= 1'b0;
         end
      end
   end

   // count input stalls and compare each output transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_ready) begin
            input_stall_cycles++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch("output with none expected", '0, rsp_output_value);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_output_value !== want) begin
                  report_mismatch("output_value", want, rsp_output_value);
               end
            end
            results_checked++;
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run limit of %0d cycles reached, %0d outputs still expected",
               RUN_LIMIT, expected_outputs.size());
      $display("tb: errors");
      $finish;
   end

   // reset, then the tests in turn
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = tossf_pkg::KIND_SAMPLE;
      req_sample       = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      sender_idles     = 1'b1;
      receiver_idles   = 1'b1;
      hold_requests    = 0;
      hold_cycles      = 0;
      error_count      = 0;
      samples_sent     = 0;
      loads_sent       = 0;
      csr_writes       = 0;
      for (int r = 0; r < 7; r++) begin
         model_regs[r] = '0;
      end
      for (int i = 0; i < tossf_pkg::STATE_ORDER; i++) begin
         model_x[i] = '0;
      end
      model_u_prev = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_saturation();
      test_load_items();
      test_random_phases();
      test_output_hold();

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_outputs.size() != 0) begin
         report_mismatch("output never arrived", expected_outputs[0], '0);
      end
      $display("covered %0d samples and %0d loads over %0d register writes, %0d outputs checked",
               samples_sent, loads_sent, csr_writes, results_checked);
      $display("input held off for %0d cycles while outputs waited", input_stall_cycles);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[third_order_state_space_filter_core.f]
rtl/tossf_pkg.sv
rtl/third_order_state_space_filter_core.sv
test/tb.sv
